// ----- src/assert_macros.svh -----
// Assertion macros used by the checker of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

// ----- src/qrrd_pkg.sv -----
`default_nettype none
package qrrd_pkg;

	localparam int CMD_W   = 2;
	localparam int CLASS_W = 2;
	localparam int QUOTA_W = 8;
	localparam int CFG_IDX_W = 2;
	localparam int NUM_CLASSES = 4;
	localparam int NUM_SPECIALISTS = 3;

	// commands
	localparam logic [CMD_W-1:0] CMD_ENQ = 2'd0;
	localparam logic [CMD_W-1:0] CMD_FIN = 2'd1;
	localparam logic [CMD_W-1:0] CMD_REQ = 2'd2;
	localparam logic [CMD_W-1:0] CMD_NOP = 2'd3;

	// classes
	localparam logic [CLASS_W-1:0] CLS_GENERAL = 2'd0;
	localparam logic [CLASS_W-1:0] CLS_SPEC1   = 2'd1;
	localparam logic [CLASS_W-1:0] CLS_SPEC2   = 2'd2;
	localparam logic [CLASS_W-1:0] CLS_SPEC3   = 2'd3;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_QUOTA_SPEC1 = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_QUOTA_SPEC2 = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_QUOTA_SPEC3 = 2'd2;

	localparam logic [QUOTA_W-1:0] QUOTA_RESET = 8'd4;

	typedef struct packed {
		logic [CMD_W-1:0]   cmd;
		logic [CLASS_W-1:0] work_class;
	} item_t;

	typedef struct packed {
		logic               grant_valid;
		logic [CLASS_W-1:0] grant_class;
		logic               rejected;
	} result_t;

	typedef struct packed {
		logic               valid;
		logic [CLASS_W-1:0] cls;
		logic [CLASS_W-1:0] next_ptr;
	} pick_t;

endpackage
`default_nettype wire

// ----- src/qrrd_pick.sv -----
`default_nettype none
// Grant choice: general first, then round-robin over the specialists.
module qrrd_pick (
	input  logic [qrrd_pkg::NUM_CLASSES-1:0]     pend_nz,
	input  logic [qrrd_pkg::NUM_SPECIALISTS-1:0] under,
	input  logic [qrrd_pkg::CLASS_W-1:0]         ptr,
	output qrrd_pkg::pick_t                      pick
);

	localparam int NS = qrrd_pkg::NUM_SPECIALISTS;

	logic [NS-1:0] spec_nz;
	logic [NS-1:0] ready;

	assign spec_nz = pend_nz[NS:1];

	// over quota is still taken when no other specialist has work
	always_comb begin
		for (int k = 0; k < NS; k++) begin
			ready[k] = spec_nz[k] &&
				(under[k] || ((spec_nz & ~(NS'(1) << k)) == '0));
		end
	end

	always_comb begin
		logic [1:0] base;
		logic [2:0] sum;
		logic [1:0] j;
		logic       found;
		logic [1:0] sel;
		case (ptr)
			qrrd_pkg::CLS_SPEC2: base = 2'd1;
			qrrd_pkg::CLS_SPEC3: base = 2'd2;
			default:             base = 2'd0;
		endcase
		found = 1'b0;
		sel   = 2'd0;
		for (int k = 0; k < NS; k++) begin
			sum = 3'(base) + 3'(k);
			j   = (sum >= 3'(NS)) ? 2'(sum - 3'(NS)) : sum[1:0];
			if (!found && ready[j]) begin
				found = 1'b1;
				sel   = j;
			end
		end
		pick.valid    = 1'b0;
		pick.cls      = qrrd_pkg::CLS_GENERAL;
		pick.next_ptr = ptr;
		if (pend_nz[qrrd_pkg::CLS_GENERAL]) begin
			pick.valid = 1'b1;
		end else if (found) begin
			pick.valid    = 1'b1;
			pick.cls      = sel + 2'd1;
			pick.next_ptr = (sel == 2'd2) ? qrrd_pkg::CLS_SPEC1 : sel + 2'd2;
		end
	end

endmodule
`default_nettype wire

// ----- src/quota_round_robin_class_dispatcher.sv -----
`default_nettype none
// Quota round-robin class dispatcher. Takes one command word per cycle
// (enqueue, finish, request or no-op on one of four classes) whenever start
// is high; busy never rises, so a word may follow in every cycle. Each word
// yields exactly one result word, shown on result for one cycle with done
// high. The command is captured in the input register; the count update and
// grant choice then load the result register, so done is high in the cycle
// after that load. The receiver cannot stall, so it must take the result in
// the cycle that done is high. Quota writes on the cfg port are always ready
// and should be made only while no command is in flight. There is no
// clearing pass after reset.
module quota_round_robin_class_dispatcher #(
	parameter int PENDING_MAX = 255,
	parameter int ACTIVE_MAX  = 255
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  qrrd_pkg::item_t                    item,
	output logic                               done,
	output qrrd_pkg::result_t                  result,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [qrrd_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [qrrd_pkg::QUOTA_W-1:0]       cfg_data
);

	localparam int NC = qrrd_pkg::NUM_CLASSES;
	localparam int NS = qrrd_pkg::NUM_SPECIALISTS;
	localparam int PW = $clog2(PENDING_MAX + 1);
	localparam int AW = $clog2(ACTIVE_MAX + 1);
	// compare width for active count against an 8-bit quota
	localparam int CW = (AW > qrrd_pkg::QUOTA_W) ? AW : qrrd_pkg::QUOTA_W;

	// Input register
	logic            valid_s1;
	qrrd_pkg::item_t item_s1;

	// State
	logic [PW-1:0]                pending_q [NC];
	logic [AW-1:0]                active_q  [NC];
	logic [qrrd_pkg::QUOTA_W-1:0] quota_q   [NS];
	logic [qrrd_pkg::CLASS_W-1:0] ptr_q;

	// Result register
	logic              done_s2;
	qrrd_pkg::result_t result_s2;

	// Next-state values
	logic [PW-1:0]                pending_d [NC];
	logic [AW-1:0]                active_d  [NC];
	logic [qrrd_pkg::CLASS_W-1:0] ptr_d;
	qrrd_pkg::result_t            result_d;

	logic [NC-1:0]   pend_nz;
	logic [NS-1:0]   under;
	qrrd_pkg::pick_t pick;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign done      = done_s2;
	assign result    = result_s2;

	// Capture each accepted word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			item_s1 <= item;
		end
	end

	// Class status for the grant choice
	always_comb begin
		for (int c = 0; c < NC; c++) begin
			pend_nz[c] = (pending_q[c] != '0);
		end
		for (int s = 0; s < NS; s++) begin
			under[s] = CW'(active_q[s+1]) < CW'(quota_q[s]);
		end
	end

	qrrd_pick u_pick (
		.pend_nz (pend_nz),
		.under   (under),
		.ptr     (ptr_q),
		.pick    (pick)
	);

	// Count updates and result for the word in the input register
	always_comb begin
		logic [qrrd_pkg::CLASS_W-1:0] cls;
		cls = item_s1.work_class;
		for (int c = 0; c < NC; c++) begin
			pending_d[c] = pending_q[c];
			active_d[c]  = active_q[c];
		end
		ptr_d    = ptr_q;
		result_d = '0;
		if (valid_s1) begin
			case (item_s1.cmd)
				qrrd_pkg::CMD_ENQ: begin
					// drop the enqueue when pending is full
					if (pending_q[cls] == PW'(PENDING_MAX)) begin
						result_d.rejected = 1'b1;
					end else begin
						pending_d[cls] = pending_q[cls] + PW'(1);
					end
				end
				qrrd_pkg::CMD_FIN: begin
					// flag a finish with nothing active
					if (active_q[cls] == '0) begin
						result_d.rejected = 1'b1;
					end else begin
						active_d[cls] = active_q[cls] - AW'(1);
					end
				end
				qrrd_pkg::CMD_REQ: begin
					if (pick.valid) begin
						result_d.grant_valid = 1'b1;
						result_d.grant_class = pick.cls;
						pending_d[pick.cls]  = pending_q[pick.cls] - PW'(1);
						// hold the active count at its ceiling
						if (active_q[pick.cls] != AW'(ACTIVE_MAX)) begin
							active_d[pick.cls] = active_q[pick.cls] + AW'(1);
						end
						ptr_d = pick.next_ptr;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Advance state and load the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < NC; c++) begin
				pending_q[c] <= '0;
				active_q[c]  <= '0;
			end
			ptr_q   <= qrrd_pkg::CLS_SPEC1;
			done_s2 <= 1'b0;
		end else begin
			for (int c = 0; c < NC; c++) begin
				pending_q[c] <= pending_d[c];
				active_q[c]  <= active_d[c];
			end
			ptr_q   <= ptr_d;
			done_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		result_s2 <= result_d;
	end

	// Quota registers; writes to an unused index are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < NS; s++) begin
				quota_q[s] <= qrrd_pkg::QUOTA_RESET;
			end
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				qrrd_pkg::REG_QUOTA_SPEC1: quota_q[0] <= cfg_data;
				qrrd_pkg::REG_QUOTA_SPEC2: quota_q[1] <= cfg_data;
				qrrd_pkg::REG_QUOTA_SPEC3: quota_q[2] <= cfg_data;
				default: begin
				end
			endcase
		end
	end

endmodule
`default_nettype wire

// ----- src/qrrd_checker.sv -----
`default_nettype none
`include "assert_macros.svh"
module qrrd_checker (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              start,
	input wire logic              busy,
	input wire qrrd_pkg::item_t   item,
	input wire logic              done,
	input wire qrrd_pkg::result_t result
);

	// every accepted word is followed by a result with done high
	`ASSERT_NEXT(a_accept_done, clk, arst_n, start && !busy, ##1 done)
	// no grant means a zero class
	`ASSERT_IMPLIES(a_nogrant_zero, clk, arst_n, done && !result.grant_valid, result.grant_class == qrrd_pkg::CLS_GENERAL)
	// a grant only answers a request
	`ASSERT_IMPLIES(a_grant_req, clk, arst_n, done && result.grant_valid, $past(item.cmd, 2) == qrrd_pkg::CMD_REQ)
	// a reject only answers an enqueue or a finish
	`ASSERT_IMPLIES(a_rej_cmd, clk, arst_n, done && result.rejected, $past(item.cmd, 2) == qrrd_pkg::CMD_ENQ || $past(item.cmd, 2) == qrrd_pkg::CMD_FIN)

endmodule

bind quota_round_robin_class_dispatcher qrrd_checker u_qrrd_checker (.*);
`default_nettype wire
